// ===== design/wavhp_pkg.sv =====
// Shared constants and types for the WAV header parser.
`default_nettype none
package wavhp_pkg;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_TOO_SMALL = 3'd1;
	localparam status_t ST_BAD_TAG   = 3'd2;
	localparam status_t ST_TRUNCATED = 3'd3;
	localparam status_t ST_NO_DATA   = 3'd4;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam int MIN_FILE_LEN = 44;
	localparam int FIRST_HEADER = 12;
	localparam int HEADER_LEN   = 8;

	// Character k of a four-character tag, first character in the top byte.
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] k);
		logic [7:0] r;
		begin
			case (k)
				2'd0:    r = tag[31:24];
				2'd1:    r = tag[23:16];
				2'd2:    r = tag[15:8];
				default: r = tag[7:0];
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== design/wavhp_in_if.sv =====
// Byte stream channel: one file byte per beat, flag on the last byte.
`default_nettype none
interface wavhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       end_of_file;

	modport source (output valid, output file_byte, output end_of_file, input ready);
	modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface
`default_nettype wire

// ===== design/wavhp_out_if.sv =====
// Result channel: one beat per parsed file.
`default_nettype none
interface wavhp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] rate_hz;
	logic [15:0] channel_count;
	logic [15:0] sample_bits;
	logic [31:0] pcm_offset;
	logic [31:0] pcm_length;
	logic        mono16_ok;

	modport source (output valid, output status, output rate_hz, output channel_count,
		output sample_bits, output pcm_offset, output pcm_length, output mono16_ok,
		input ready);
	modport sink   (input valid, input status, input rate_hz, input channel_count,
		input sample_bits, input pcm_offset, input pcm_length, input mono16_ok,
		output ready);
endinterface
`default_nettype wire

// ===== design/wavhp_chunk_walk.sv =====
// Chunk header walker: finds the first complete "data" chunk header.
`default_nettype none
module wavhp_chunk_walk #(
	parameter int POSITION_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     step,
	input  wire logic                     clear,
	input  wire logic [POSITION_BITS-1:0] pos,
	input  wire logic [7:0]               file_byte,
	output logic                          found,
	output logic [POSITION_BITS-1:0]      found_offset,
	output logic [31:0]                   found_length
);
	import wavhp_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int NW = ((PB + 1 > 32) ? PB + 1 : 32) + 2;
	localparam logic [PB:0] NEXT_MAX = {(PB + 1){1'b1}};

	logic [PB:0]   next_at_q;
	logic [31:0]   id_q;
	logic [31:0]   size_q;
	logic          found_q;
	logic [PB-1:0] off_q;
	logic [31:0]   len_q;

	logic [PB:0]   pos_ext;
	logic [PB:0]   diff;
	logic          in_hdr;
	logic [2:0]    d;
	logic [31:0]   id_d;
	logic [31:0]   size_d;
	logic [PB:0]   next_at_d;
	logic [NW-1:0] next_sum;

	always_comb begin
		pos_ext   = {1'b0, pos};
		diff      = pos_ext - next_at_q;
		d         = diff[2:0];
		in_hdr    = step && !found_q && (pos_ext >= next_at_q) && (diff[PB:3] == '0);
		id_d      = id_q;
		size_d    = size_q;
		next_at_d = next_at_q;
		found     = found_q;
		found_offset = off_q;
		found_length = len_q;
		next_sum  = NW'(next_at_q) + NW'(HEADER_LEN) + NW'(size_q);
		if (in_hdr) begin
			if (d < 3'd4) begin
				id_d = {id_q[23:0], file_byte};
			end else begin
				size_d = {file_byte, size_q[31:8]};
			end
			if (d == 3'd7) begin
				next_sum = NW'(next_at_q) + NW'(HEADER_LEN) + NW'(size_d);
				if (id_q == TAG_DATA) begin
					found        = 1'b1;
					found_offset = pos + PB'(1);
					found_length = size_d;
				end else if (next_sum > NW'(NEXT_MAX)) begin
					next_at_d = NEXT_MAX;
				end else begin
					next_at_d = next_sum[PB:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_at_q <= (PB + 1)'(FIRST_HEADER);
			id_q      <= '0;
			size_q    <= '0;
			found_q   <= 1'b0;
			off_q     <= '0;
			len_q     <= '0;
		end else if (clear) begin
			next_at_q <= (PB + 1)'(FIRST_HEADER);
			id_q      <= '0;
			size_q    <= '0;
			found_q   <= 1'b0;
			off_q     <= '0;
			len_q     <= '0;
		end else if (step) begin
			next_at_q <= next_at_d;
			id_q      <= id_d;
			size_q    <= size_d;
			found_q   <= found;
			off_q     <= found_offset;
			len_q     <= found_length;
		end
	end

`ifndef SYNTHESIS
	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && !clear |=> found_q)
		else $error("data chunk flag dropped inside a file");
	a_walk_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && !clear |=> $stable(next_at_q))
		else $error("chunk walk advanced after data chunk was found");
	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> !found_q && next_at_q == (PB + 1)'(FIRST_HEADER))
		else $error("walker not back at first header after file end");
`endif

endmodule
`default_nettype wire

// ===== design/wav_header_parser.sv =====
// WAV header parser: streams a file byte by byte and reports its format.
//
// Usage:
//   stream carries one file byte per beat; end_of_file marks the last byte.
//   result carries one beat per file: status, sample rate, channel count,
//   bits per sample, PCM data offset and length, and a mono 16-bit flag.
//   An accepted byte is held in an input register and parsed from there
//   against the running state; on the last byte the parse loads the result
//   register, which drives the result beat.
//   Throughput is one byte per cycle, set by the single input register, but
//   a final byte waits on a held result; other bytes keep flowing meanwhile.
//   When the receiver stalls, the result register holds; only a new final
//   byte waits in the input register until the result beat is taken, which
//   in turn stalls stream.
//   Reset clears the position counter, tag checks and chunk walk; after each
//   final byte the same state is cleared so the next byte starts a new file.
//   Positions are POSITION_BITS wide and saturate at their maximum.
`default_nettype none
module wav_header_parser #(
	parameter int POSITION_BITS = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wavhp_in_if.sink   stream,
	wavhp_out_if.source result
);
	import wavhp_pkg::*;

	localparam int PB  = POSITION_BITS;
	localparam int SUM = ((PB > 32) ? PB : 32) + 1;
	localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          eof_s1;
	logic          adv;
	logic          fin;
	logic          parse_en;

	logic [PB-1:0] pos_q;
	logic          riff_q;
	logic          wave_q;
	logic [31:0]   rate_q;
	logic [15:0]   ch_q;
	logic [15:0]   bits_q;

	logic          found;
	logic [PB-1:0] found_offset;
	logic [31:0]   found_length;

	logic          res_valid_q;
	status_t       status_q;
	logic [31:0]   rate_out_q;
	logic [15:0]   ch_out_q;
	logic [15:0]   bits_out_q;
	logic [31:0]   off_out_q;
	logic [31:0]   len_out_q;
	logic          mono_q;

	logic [PB:0]    file_len;
	logic [SUM-1:0] off_ext;
	logic [SUM-1:0] chunk_end;
	status_t        status_d;

	// Advance the input register unless a final byte would overwrite a held result.
	assign adv          = valid_s1 && (!eof_s1 || !res_valid_q || result.ready);
	assign fin          = adv && eof_s1;
	assign parse_en     = adv && (pos_q != POS_MAX);
	assign stream.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.file_byte;
			eof_s1  <= stream.end_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			riff_q <= 1'b1;
			wave_q <= 1'b1;
			rate_q <= '0;
			ch_q   <= '0;
			bits_q <= '0;
		end else if (fin) begin
			pos_q  <= '0;
			riff_q <= 1'b1;
			wave_q <= 1'b1;
			rate_q <= '0;
			ch_q   <= '0;
			bits_q <= '0;
		end else if (adv) begin
			if (pos_q != POS_MAX) begin
				pos_q <= pos_q + PB'(1);
			end
			if (parse_en) begin
				if (pos_q < PB'(4) && byte_s1 != tag_byte(TAG_RIFF, pos_q[1:0])) begin
					riff_q <= 1'b0;
				end
				if (pos_q >= PB'(8) && pos_q < PB'(12) &&
				    byte_s1 != tag_byte(TAG_WAVE, pos_q[1:0])) begin
					wave_q <= 1'b0;
				end
				if (pos_q == PB'(22) || pos_q == PB'(23)) begin
					ch_q <= {byte_s1, ch_q[15:8]};
				end
				if (pos_q >= PB'(24) && pos_q < PB'(28)) begin
					rate_q <= {byte_s1, rate_q[31:8]};
				end
				if (pos_q == PB'(34) || pos_q == PB'(35)) begin
					bits_q <= {byte_s1, bits_q[15:8]};
				end
			end
		end
	end

	wavhp_chunk_walk #(
		.POSITION_BITS (PB)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (parse_en),
		.clear        (fin),
		.pos          (pos_q),
		.file_byte    (byte_s1),
		.found        (found),
		.found_offset (found_offset),
		.found_length (found_length)
	);

	always_comb begin
		file_len  = {1'b0, pos_q} + (PB + 1)'(1);
		off_ext   = SUM'(found_offset);
		chunk_end = off_ext + SUM'(found_length);
		if (file_len < (PB + 1)'(MIN_FILE_LEN)) begin
			status_d = ST_TOO_SMALL;
		end else if (!riff_q || !wave_q) begin
			status_d = ST_BAD_TAG;
		end else if (!found) begin
			status_d = ST_NO_DATA;
		end else if (chunk_end > SUM'(file_len)) begin
			status_d = ST_TRUNCATED;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			status_q <= status_d;
			if (status_d == ST_TOO_SMALL || status_d == ST_BAD_TAG) begin
				rate_out_q <= '0;
				ch_out_q   <= '0;
				bits_out_q <= '0;
			end else begin
				rate_out_q <= rate_q;
				ch_out_q   <= ch_q;
				bits_out_q <= bits_q;
			end
			if (status_d == ST_OK) begin
				off_out_q <= off_ext[31:0];
				len_out_q <= found_length;
				mono_q    <= (ch_q == 16'd1) && (bits_q == 16'd16);
			end else begin
				off_out_q <= '0;
				len_out_q <= '0;
				mono_q    <= 1'b0;
			end
		end
	end

	assign result.valid         = res_valid_q;
	assign result.status        = status_q;
	assign result.rate_hz       = rate_out_q;
	assign result.channel_count = ch_out_q;
	assign result.sample_bits   = bits_out_q;
	assign result.pcm_offset    = off_out_q;
	assign result.pcm_length    = len_out_q;
	assign result.mono16_ok     = mono_q;

`ifndef SYNTHESIS
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> pos_q == '0)
		else $error("position not cleared after final byte");
	a_final_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && eof_s1 && res_valid_q && !result.ready |-> !stream.ready)
		else $error("final byte advanced over a held result");
	a_mono_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && mono_q |-> status_q == ST_OK)
		else $error("mono flag set on a failed file");
	a_pos_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !eof_s1 |=> pos_q >= $past(pos_q))
		else $error("position moved backward inside a file");
`endif

endmodule
`default_nettype wire
